// ===== rtl/core/btc_pkg.sv =====
// ---------------------------------------------------------------------------
// btc_pkg: shared types and constants of the button tap/hold classifier
// Field widths, event codes, register indexes and register reset values.
// ---------------------------------------------------------------------------
package btc_pkg;

  // field widths
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned TAPS_W  = 8;
  localparam int unsigned INDEX_W = 3;

  typedef logic [TIME_W-1:0]  time_ms_t;
  typedef logic [CFG_W-1:0]   cfg_word_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [TAPS_W-1:0]  taps_t;
  typedef logic [INDEX_W-1:0] cfg_index_t;

  // event codes
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_TAPS = 2'd1;
  localparam kind_t KIND_HOLD = 2'd2;
  localparam kind_t KIND_MENU = 2'd3;

  // tap count saturation
  localparam taps_t TAP_LIMIT = 8'd250;

  // register indexes
  localparam cfg_index_t REG_DEBOUNCE  = 3'd0;
  localparam cfg_index_t REG_HOLD      = 3'd1;
  localparam cfg_index_t REG_MENU_HOLD = 3'd2;
  localparam cfg_index_t REG_TAP_GAP   = 3'd3;
  localparam cfg_index_t REG_TAP_RESET = 3'd4;
  localparam cfg_index_t REG_ACTIVE_LO = 3'd5;

  // register reset values
  localparam cfg_word_t RST_DEBOUNCE  = 16'd30;
  localparam cfg_word_t RST_HOLD      = 16'd600;
  localparam cfg_word_t RST_MENU_HOLD = 16'd2000;
  localparam cfg_word_t RST_TAP_GAP   = 16'd350;
  localparam cfg_word_t RST_TAP_RESET = 16'd1500;
  localparam logic      RST_ACTIVE_LO = 1'b1;

endpackage

// ===== rtl/core/btc_in_if.sv =====
// ---------------------------------------------------------------------------
// btc_in_if: sample channel
// Valid/ready channel carrying one button sample per beat.
// ---------------------------------------------------------------------------
interface btc_in_if;
  import btc_pkg::*;

  logic     valid;
  logic     ready;
  time_ms_t now_time;
  logic     pin_level;
  logic     consume;

  modport source (output valid, output now_time, output pin_level, output consume,
                  input ready);
  modport sink   (input valid, input now_time, input pin_level, input consume,
                  output ready);
endinterface

// ===== rtl/core/btc_out_if.sv =====
// ---------------------------------------------------------------------------
// btc_out_if: result channel
// Valid/ready channel carrying the pending event and debounced state per beat.
// ---------------------------------------------------------------------------
interface btc_out_if;
  import btc_pkg::*;

  logic  valid;
  logic  ready;
  kind_t event_kind;
  taps_t event_taps;
  logic  pressed_now;

  modport source (output valid, output event_kind, output event_taps,
                  output pressed_now, input ready);
  modport sink   (input valid, input event_kind, input event_taps,
                  input pressed_now, output ready);
endinterface

// ===== rtl/core/button_tap_hold_classifier.sv =====
// ---------------------------------------------------------------------------
// button_tap_hold_classifier: debounced button with tap and hold detection
// Debounces a timestamped pin sample stream, classifies presses into taps,
// hold and menu hold, and reports a one-slot pending event per sample.
// ---------------------------------------------------------------------------
//  channel   | dir | beat contents                         | handshake
//  ----------+-----+---------------------------------------+-------------
//  in_ch     | in  | now_time[31:0], pin_level, consume    | valid/ready
//  out_ch    | out | event_kind[1:0], event_taps[7:0],     | valid/ready
//            |     | pressed_now                           |
//  cfg       | in  | cfg_index[2:0], cfg_data[15:0]        | cfg_we only
//
//  One sample per cycle sustained while out_ch is ready; a sample is captured
//  in the sample register, then the classifier update lands in the result register.
//  rst is synchronous: state and registers return to defaults, button released.
//  A stalled out_ch holds its beat; in_ch keeps filling the sample register
//  while the result register is free or being drained in the same cycle.
// ---------------------------------------------------------------------------
module button_tap_hold_classifier (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  btc_pkg::cfg_index_t   cfg_index,
  input  btc_pkg::cfg_word_t    cfg_data,
  btc_in_if.sink                in_ch,
  btc_out_if.source             out_ch
);
  import btc_pkg::*;

  // configuration
  cfg_word_t debounce_time;
  cfg_word_t hold_time;
  cfg_word_t menu_hold_time;
  cfg_word_t tap_gap_time;
  cfg_word_t tap_reset_time;
  logic      active_low;

  // sample register
  logic     smp_valid;
  time_ms_t smp_now;
  logic     smp_pin;
  logic     smp_consume;

  // classifier state
  logic     raw_last, raw_last_next;
  logic     stable_state, stable_state_next;
  time_ms_t raw_change_time, raw_change_time_next;
  time_ms_t press_start_time, press_start_time_next;
  taps_t    tap_total, tap_total_next;
  taps_t    emitted_taps, emitted_taps_next;
  time_ms_t last_tap_time, last_tap_time_next;
  kind_t    pending_kind, pending_kind_next;
  taps_t    pending_taps, pending_taps_next;

  // result register
  logic  res_valid;
  kind_t res_kind;
  taps_t res_taps;
  logic  res_pressed;

  logic     advance;
  logic     pressed;
  time_ms_t since_change;
  time_ms_t held;
  time_ms_t since_tap;

  // flow control
  assign advance     = smp_valid && (!res_valid || out_ch.ready);
  assign in_ch.ready = !smp_valid || advance;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_time  <= RST_DEBOUNCE;
      hold_time      <= RST_HOLD;
      menu_hold_time <= RST_MENU_HOLD;
      tap_gap_time   <= RST_TAP_GAP;
      tap_reset_time <= RST_TAP_RESET;
      active_low     <= RST_ACTIVE_LO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEBOUNCE:  debounce_time  <= cfg_data;
        REG_HOLD:      hold_time      <= cfg_data;
        REG_MENU_HOLD: menu_hold_time <= cfg_data;
        REG_TAP_GAP:   tap_gap_time   <= cfg_data;
        REG_TAP_RESET: tap_reset_time <= cfg_data;
        REG_ACTIVE_LO: active_low     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_ch.ready) begin
      smp_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      smp_now     <= in_ch.now_time;
      smp_pin     <= in_ch.pin_level;
      smp_consume <= in_ch.consume;
    end
  end

  // classifier update for the sample in the register
  always_comb begin
    raw_last_next         = raw_last;
    stable_state_next     = stable_state;
    raw_change_time_next  = raw_change_time;
    press_start_time_next = press_start_time;
    tap_total_next        = tap_total;
    emitted_taps_next     = emitted_taps;
    last_tap_time_next    = last_tap_time;
    pending_kind_next     = pending_kind;
    pending_taps_next     = pending_taps;

    pressed = active_low ? ~smp_pin : smp_pin;
    held    = smp_now - press_start_time;

    // track raw edges
    if (pressed != raw_last) begin
      raw_last_next        = pressed;
      raw_change_time_next = smp_now;
    end

    // debounce and press classification
    since_change = smp_now - raw_change_time_next;
    if (since_change >= {16'd0, debounce_time} && pressed != stable_state) begin
      stable_state_next = pressed;
      if (pressed) begin
        press_start_time_next = smp_now;
      end else if (held >= {16'd0, menu_hold_time}) begin
        tap_total_next    = '0;
        emitted_taps_next = '0;
        if (pending_kind == KIND_NONE) begin
          pending_kind_next = KIND_MENU;
          pending_taps_next = '0;
        end
      end else if (held >= {16'd0, hold_time}) begin
        tap_total_next    = '0;
        emitted_taps_next = '0;
        if (pending_kind == KIND_NONE) begin
          pending_kind_next = KIND_HOLD;
          pending_taps_next = '0;
        end
      end else begin
        if (tap_total < TAP_LIMIT) begin
          tap_total_next = tap_total + 8'd1;
        end
        last_tap_time_next = smp_now;
      end
    end

    // tap sequence emission, then count expiry
    since_tap = smp_now - last_tap_time_next;
    if (!stable_state_next && tap_total_next != '0 && emitted_taps_next != tap_total_next &&
        since_tap >= {16'd0, tap_gap_time}) begin
      if (pending_kind_next == KIND_NONE) begin
        pending_kind_next = KIND_TAPS;
        pending_taps_next = tap_total_next;
      end
      emitted_taps_next = tap_total_next;
    end
    if (!stable_state_next && tap_total_next != '0 &&
        since_tap >= {16'd0, tap_reset_time}) begin
      tap_total_next    = '0;
      emitted_taps_next = '0;
    end
  end

  // classifier state register
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_last         <= 1'b0;
      stable_state     <= 1'b0;
      raw_change_time  <= '0;
      press_start_time <= '0;
      tap_total        <= '0;
      emitted_taps     <= '0;
      last_tap_time    <= '0;
      pending_kind     <= KIND_NONE;
      pending_taps     <= '0;
    end else if (advance) begin
      raw_last         <= raw_last_next;
      stable_state     <= stable_state_next;
      raw_change_time  <= raw_change_time_next;
      press_start_time <= press_start_time_next;
      tap_total        <= tap_total_next;
      emitted_taps     <= emitted_taps_next;
      last_tap_time    <= last_tap_time_next;
      // consume clears the slot after this beat's result
      pending_kind     <= smp_consume ? KIND_NONE : pending_kind_next;
      pending_taps     <= smp_consume ? '0 : pending_taps_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (out_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_kind    <= pending_kind_next;
      res_taps    <= pending_taps_next;
      res_pressed <= stable_state_next;
    end
  end

  assign out_ch.valid       = res_valid;
  assign out_ch.event_kind  = res_kind;
  assign out_ch.event_taps  = res_taps;
  assign out_ch.pressed_now = res_pressed;

endmodule

// ===== verif/btc_event_checker.sv =====
// ---------------------------------------------------------------------------
// btc_event_checker: result predictor and scoreboard for the classifier
// Watches the sample and result channels and the register write port. Keeps
// its own debounce/tap/hold state, predicts one result per accepted sample
// and compares every result beat, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module btc_event_checker (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  btc_pkg::cfg_index_t cfg_index,
  input  btc_pkg::cfg_word_t  cfg_data,
  btc_in_if                   in_mon,
  btc_out_if                  out_mon,
  output int                  fail_count,
  output int                  outstanding,
  output int                  checked,
  output int                  tap_seq_seen,
  output int                  hold_seen,
  output int                  menu_seen
);
  import btc_pkg::*;

  typedef struct packed {
    kind_t kind;
    taps_t taps;
    logic  pressed;
  } btn_result_t;

  // register copies
  cfg_word_t cfg_debounce;
  cfg_word_t cfg_hold;
  cfg_word_t cfg_menu;
  cfg_word_t cfg_gap;
  cfg_word_t cfg_clear;
  logic      cfg_active_lo;

  // classifier state
  logic     btn_raw;
  logic     btn_stable;
  time_ms_t raw_edge_ms;
  time_ms_t press_ms;
  taps_t    tap_count;
  taps_t    taps_reported;
  time_ms_t tap_ms;
  kind_t    slot_kind;
  taps_t    slot_taps;

  btn_result_t due_q[$];
  btn_result_t fresh_beat;
  btn_result_t due_beat;
  btn_result_t seen_beat;

  int errors;
  int beats_done;
  int n_taps;
  int n_hold;
  int n_menu;

  initial begin
    errors     = 0;
    beats_done = 0;
    n_taps     = 0;
    n_hold     = 0;
    n_menu     = 0;
  end

  task automatic reset_classifier();
    cfg_debounce  = RST_DEBOUNCE;
    cfg_hold      = RST_HOLD;
    cfg_menu      = RST_MENU_HOLD;
    cfg_gap       = RST_TAP_GAP;
    cfg_clear     = RST_TAP_RESET;
    cfg_active_lo = RST_ACTIVE_LO;
    btn_raw       = 1'b0;
    btn_stable    = 1'b0;
    raw_edge_ms   = '0;
    press_ms      = '0;
    tap_count     = '0;
    taps_reported = '0;
    tap_ms        = '0;
    slot_kind     = KIND_NONE;
    slot_taps     = '0;
  endtask

  task automatic apply_register(input cfg_index_t idx, input cfg_word_t data);
    case (idx)
      REG_DEBOUNCE:  cfg_debounce  = data;
      REG_HOLD:      cfg_hold      = data;
      REG_MENU_HOLD: cfg_menu      = data;
      REG_TAP_GAP:   cfg_gap       = data;
      REG_TAP_RESET: cfg_clear     = data;
      REG_ACTIVE_LO: cfg_active_lo = data[0];
      default: ;
    endcase
  endtask

  // one-slot event register: the first raised event sticks until consumed
  task automatic post_event(input kind_t kind, input taps_t taps);
    if (slot_kind == KIND_NONE) begin
      slot_kind = kind;
      slot_taps = taps;
    end
  endtask

  task automatic classify_sample(input time_ms_t now, input logic level, input logic take,
                                 output btn_result_t res);
    logic     pressed;
    time_ms_t since_edge;
    time_ms_t held;
    time_ms_t since_tap;
    pressed = cfg_active_lo ? ~level : level;
    if (pressed != btn_raw) begin
      btn_raw     = pressed;
      raw_edge_ms = now;
    end
    // debounced transition
    since_edge = now - raw_edge_ms;
    if (since_edge >= time_ms_t'(cfg_debounce) && pressed != btn_stable) begin
      btn_stable = pressed;
      if (btn_stable) begin
        press_ms = now;
      end else begin
        held = now - press_ms;
        // menu hold wins over hold whatever the thresholds
        if (held >= time_ms_t'(cfg_menu)) begin
          tap_count     = '0;
          taps_reported = '0;
          post_event(KIND_MENU, '0);
        end else if (held >= time_ms_t'(cfg_hold)) begin
          tap_count     = '0;
          taps_reported = '0;
          post_event(KIND_HOLD, '0);
        end else begin
          if (tap_count < TAP_LIMIT) tap_count = tap_count + 8'd1;
          tap_ms = now;
        end
      end
    end
    // emit the tap sequence once, then clear the count; emission goes first
    since_tap = now - tap_ms;
    if (!btn_stable && tap_count != '0 && taps_reported != tap_count &&
        since_tap >= time_ms_t'(cfg_gap)) begin
      post_event(KIND_TAPS, tap_count);
      taps_reported = tap_count;
    end
    if (!btn_stable && tap_count != '0 && since_tap >= time_ms_t'(cfg_clear)) begin
      tap_count     = '0;
      taps_reported = '0;
    end
    res.kind    = slot_kind;
    res.taps    = slot_taps;
    res.pressed = btn_stable;
    if (take) begin
      slot_kind = KIND_NONE;
      slot_taps = '0;
    end
  endtask

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // predict on every sample beat, compare on every result beat
  always @(posedge clk) begin
    if (rst) begin
      reset_classifier();
      due_q.delete();
    end else begin
      if (cfg_we) apply_register(cfg_index, cfg_data);
      if (in_mon.valid && in_mon.ready) begin
        classify_sample(in_mon.now_time, in_mon.pin_level, in_mon.consume, fresh_beat);
        due_q.push_back(fresh_beat);
      end
      if (out_mon.valid && out_mon.ready) begin
        seen_beat = '{out_mon.event_kind, out_mon.event_taps, out_mon.pressed_now};
        if (due_q.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual kind %0d taps %0d pressed %0d",
                   $time, seen_beat.kind, seen_beat.taps, seen_beat.pressed);
        end else begin
          due_beat = due_q.pop_front();
          check_field("event_kind", 32'(due_beat.kind), 32'(seen_beat.kind));
          check_field("event_taps", 32'(due_beat.taps), 32'(seen_beat.taps));
          check_field("pressed_now", 32'(due_beat.pressed), 32'(seen_beat.pressed));
          beats_done++;
          case (seen_beat.kind)
            KIND_TAPS: n_taps++;
            KIND_HOLD: n_hold++;
            KIND_MENU: n_menu++;
            default: ;
          endcase
        end
      end
    end
    outstanding  <= due_q.size();
    fail_count   <= errors;
    checked      <= beats_done;
    tap_seq_seen <= n_taps;
    hold_seen    <= n_hold;
    menu_seen    <= n_menu;
  end

endmodule

// ===== verif/button_tap_hold_classifier_tb.sv =====
// ---------------------------------------------------------------------------
// button_tap_hold_classifier_tb: stimulus and verdict for the classifier
// Drives timestamped button samples (bounce, taps, holds, menu holds, noise
// and time jumps) under several register settings with random idling on both
// channels; the checker beside the block predicts and compares every result.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module button_tap_hold_classifier_tb;
  import btc_pkg::*;

  // indexes past the register file, which the block must ignore
  localparam cfg_index_t REG_SPARE_LO = 3'd6;
  localparam cfg_index_t REG_SPARE_HI = 3'd7;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_we;
  cfg_index_t cfg_index;
  cfg_word_t  cfg_data;

  btc_in_if  in_bus();
  btc_out_if out_bus();

  int fail_count;
  int outstanding;
  int checked;
  int tap_seq_seen;
  int hold_seen;
  int menu_seen;

  // stimulus state
  time_ms_t    clock_ms;
  int unsigned cur_deb;
  int unsigned cur_hold;
  int unsigned cur_menu;
  int unsigned cur_gap;
  int unsigned cur_clear;
  logic        cur_lo;
  logic        calm;
  int unsigned samples_sent;
  int unsigned settings_applied;
  int unsigned rx_stall;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_tap_hold_classifier u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  btc_event_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_mon       (in_bus),
    .out_mon      (out_bus),
    .fail_count   (fail_count),
    .outstanding  (outstanding),
    .checked      (checked),
    .tap_seq_seen (tap_seq_seen),
    .hold_seen    (hold_seen),
    .menu_seen    (menu_seen)
  );

  function automatic logic take_coin();
    return $urandom_range(0, 3) == 0;
  endfunction

  // one sample beat; pr is the intended pressed state under the current polarity
  task automatic press_sample(input time_ms_t t, input logic pr, input logic take);
    int unsigned gap;
    if (!calm && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 18);
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.now_time  <= t;
    in_bus.pin_level <= cur_lo ? ~pr : pr;
    in_bus.consume   <= take;
    do @(posedge clk); while (!in_bus.ready);
    samples_sent++;
  endtask

  // stop sending and wait until every result has come back
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_beat(input cfg_index_t idx, input cfg_word_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // full register set, written only once the block is idle
  task automatic load_settings(input cfg_word_t deb, input cfg_word_t hold,
                               input cfg_word_t menu, input cfg_word_t gap,
                               input cfg_word_t clr, input logic lo);
    wait_drained();
    cfg_beat(REG_DEBOUNCE, deb);
    cfg_beat(REG_HOLD, hold);
    cfg_beat(REG_MENU_HOLD, menu);
    cfg_beat(REG_TAP_GAP, gap);
    cfg_beat(REG_TAP_RESET, clr);
    // upper bits are junk: only bit 0 counts
    cfg_beat(REG_ACTIVE_LO, {15'($urandom()), lo});
    cfg_beat(REG_SPARE_LO, 16'($urandom()));
    cfg_beat(REG_SPARE_HI, 16'($urandom()));
    cfg_we <= 1'b0;
    @(posedge clk);
    cur_deb   = 32'(deb);
    cur_hold  = 32'(hold);
    cur_menu  = 32'(menu);
    cur_gap   = 32'(gap);
    cur_clear = 32'(clr);
    cur_lo    = lo;
    settings_applied++;
  endtask

  // contact bounce: short alternating samples
  task automatic chatter();
    repeat ($urandom_range(1, 3)) begin
      clock_ms += time_ms_t'($urandom_range(0, 3));
      press_sample(clock_ms, 1'b1, take_coin());
      clock_ms += time_ms_t'($urandom_range(0, 3));
      press_sample(clock_ms, 1'b0, take_coin());
    end
  endtask

  // a level held for roughly span ms, sampled a few times
  task automatic hold_level(input logic pr, input int unsigned span);
    int unsigned n;
    n = $urandom_range(1, 4);
    clock_ms += time_ms_t'($urandom_range(0, 2));
    press_sample(clock_ms, pr, take_coin());
    repeat (n) begin
      clock_ms += time_ms_t'(span / n);
      press_sample(clock_ms, pr, take_coin());
    end
  endtask

  // press and release with lengths picked around the current thresholds
  task automatic press_gesture();
    int unsigned held;
    int unsigned quiet;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5)      held = $urandom_range(0, cur_hold);
    else if (pick < 8) held = $urandom_range(cur_hold, cur_menu);
    else               held = cur_menu + $urandom_range(0, 200);
    pick = $urandom_range(0, 9);
    if (pick < 5)      quiet = $urandom_range(0, cur_gap);
    else if (pick < 8) quiet = $urandom_range(cur_gap, cur_clear);
    else               quiet = cur_clear + $urandom_range(0, 200);
    if ($urandom_range(0, 3) == 0) chatter();
    hold_level(1'b1, cur_deb + held);
    if ($urandom_range(0, 3) == 0) chatter();
    hold_level(1'b0, cur_deb + quiet);
  endtask

  // mostly well-formed gestures, the rest random levels and time jumps
  task automatic run_phase(input int unsigned items);
    int unsigned stop_at;
    stop_at = samples_sent + items;
    while (samples_sent < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        press_gesture();
      end else begin
        if ($urandom_range(0, 3) == 0) clock_ms = time_ms_t'($urandom());
        else clock_ms += time_ms_t'($urandom_range(0, cur_deb + 5));
        press_sample(clock_ms, 1'($urandom_range(0, 1)), take_coin());
      end
    end
  endtask

  // result side: random stall bursts, none in the calm tail
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        rx_stall = $urandom_range(1, 18);
        out_bus.ready <= 1'b0;
        repeat (rx_stall - 1) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst              <= 1'b1;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_DEBOUNCE;
    cfg_data         <= '0;
    in_bus.valid     <= 1'b0;
    in_bus.now_time  <= '0;
    in_bus.pin_level <= 1'b1;
    in_bus.consume   <= 1'b0;
    calm             = 1'b0;
    samples_sent     = 0;
    settings_applied = 1;
    cur_deb          = 32'(RST_DEBOUNCE);
    cur_hold         = 32'(RST_HOLD);
    cur_menu         = 32'(RST_MENU_HOLD);
    cur_gap          = 32'(RST_TAP_GAP);
    cur_clear        = 32'(RST_TAP_RESET);
    cur_lo           = RST_ACTIVE_LO;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed, reset settings: bounce, two taps, emission, consume, hold,
    // menu hold dropped while the slot is full, menu hold across the wrap
    press_sample(32'd0,    1'b0, 1'b0);
    press_sample(32'd5,    1'b1, 1'b0);
    press_sample(32'd10,   1'b0, 1'b0);
    press_sample(32'd15,   1'b1, 1'b0);
    press_sample(32'd45,   1'b1, 1'b0);
    press_sample(32'd100,  1'b0, 1'b0);
    press_sample(32'd130,  1'b0, 1'b0);
    press_sample(32'd200,  1'b1, 1'b0);
    press_sample(32'd230,  1'b1, 1'b0);
    press_sample(32'd260,  1'b0, 1'b0);
    press_sample(32'd290,  1'b0, 1'b0);
    press_sample(32'd700,  1'b0, 1'b0);
    press_sample(32'd710,  1'b0, 1'b1);
    press_sample(32'd800,  1'b1, 1'b0);
    press_sample(32'd830,  1'b1, 1'b0);
    press_sample(32'd1500, 1'b0, 1'b0);
    press_sample(32'd1530, 1'b0, 1'b0);
    press_sample(32'd1600, 1'b1, 1'b0);
    press_sample(32'd1630, 1'b1, 1'b0);
    press_sample(32'd3700, 1'b0, 1'b0);
    press_sample(32'd3730, 1'b0, 1'b1);
    press_sample(32'hFFFF_FFF0, 1'b1, 1'b0);
    press_sample(32'h0000_0010, 1'b1, 1'b0);
    press_sample(32'h0000_0A00, 1'b0, 1'b0);
    press_sample(32'h0000_0A20, 1'b0, 1'b1);
    clock_ms = 32'h0000_0B00;

    // reset settings, random
    run_phase(150);

    // tight thresholds
    load_settings(16'd10, 16'd200, 16'd800, 16'd150, 16'd600, 1'b1);
    run_phase(200);

    // active high, very short times
    load_settings(16'd0, 16'd50, 16'd100, 16'd40, 16'd120, 1'b0);
    run_phase(200);

    // tap saturation: no debounce, gap and clear equal so both fire together
    load_settings(16'd0, 16'd1000, 16'd2000, 16'hFFFF, 16'hFFFF, 1'b0);
    clock_ms += 32'd1;
    press_sample(clock_ms, 1'b0, 1'b1);
    repeat (260) begin
      clock_ms += 32'd1;
      press_sample(clock_ms, 1'b1, 1'b0);
      clock_ms += 32'd1;
      press_sample(clock_ms, 1'b0, 1'b0);
    end
    clock_ms += 32'd65535;
    press_sample(clock_ms, 1'b0, 1'b0);
    clock_ms += 32'd1;
    press_sample(clock_ms, 1'b0, 1'b1);

    // menu threshold below hold, clear before gap
    load_settings(16'd5, 16'd500, 16'd100, 16'd300, 16'd200, 1'b1);
    run_phase(200);

    // all thresholds at zero
    load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    run_phase(100);

    // all thresholds at maximum, crossing the time wrap
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    clock_ms = 32'hFFF0_0000;
    run_phase(80);

    // random settings
    repeat (2) begin
      load_settings(16'($urandom_range(0, 40)), 16'($urandom_range(0, 800)),
                    16'($urandom_range(0, 2500)), 16'($urandom_range(0, 500)),
                    16'($urandom_range(0, 2000)), 1'($urandom_range(0, 1)));
      run_phase(150);
    end

    // calm tail: reset values, no idling on either side
    load_settings(RST_DEBOUNCE, RST_HOLD, RST_MENU_HOLD, RST_TAP_GAP, RST_TAP_RESET,
                  RST_ACTIVE_LO);
    calm = 1'b1;
    run_phase(150);

    wait_drained();
    repeat (4) @(posedge clk);
    $display("Summary: %0d samples sent under %0d register settings, %0d results checked",
             samples_sent, settings_applied, checked);
    $display("Summary: beats showing tap sequence %0d, hold %0d, menu hold %0d",
             tap_seq_seen, hold_seen, menu_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
